FILE: sv/red_black_laplace_relaxation_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the red-black Laplace relaxation block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RED_BLACK_LAPLACE_RELAXATION_ASSERT_SVH
`define RED_BLACK_LAPLACE_RELAXATION_ASSERT_SVH

// Same-cycle implication
`define RBL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RBL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/rbl_pkg.sv
// ----------------------------------------------------------------------------
// rbl_pkg
// Shared types and constants of the red-black Laplace relaxation block.
// ----------------------------------------------------------------------------
package rbl_pkg;

	// stream payload widths
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;
	localparam int IN_TUSER_W  = 2;

	// input tdata field positions
	localparam int ROW_LSB  = 0;
	localparam int COL_LSB  = 6;
	localparam int CELL_LSB = 12;
	localparam int COORD_W  = 6;
	localparam int CELL_W   = 32;

	// configuration registers
	localparam int GSIZE_W    = 7;
	localparam int SWEEP_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam logic CFG_GRID_SIZE   = 1'b0;
	localparam logic CFG_SWEEP_COUNT = 1'b1;
	localparam logic [GSIZE_W-1:0] GRID_SIZE_RST   = 7'd64;
	localparam logic [SWEEP_W-1:0] SWEEP_COUNT_RST = 16'd1;

	// operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_CELL,
		S_LR,
		S_SUM,
		S_WB,
		S_RESP
	} rbl_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic run_init;
		logic wr_cell;
		logic rd_cell;
		logic rd_ud;
		logic rd_lr;
		logic sum_ud;
		logic sum_all;
		logic wb;
		logic advance;
		logic out_load;
	} rbl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic run_empty;
		logic cell_odd;
		logic scan_end;
		logic out_free;
	} rbl_status_t;

endpackage

FILE: sv/rbl_ram.sv
// ----------------------------------------------------------------------------
// rbl_ram
// Generic RAM: one write port, two read ports, registered read data that
// holds while no read is issued.
// ----------------------------------------------------------------------------
module rbl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: sv/rbl_ctrl.sv
// ----------------------------------------------------------------------------
// rbl_ctrl
// Sequencer: takes requests, steps the datapath through writes, reads and
// the per-cell read/add/write-back of a run, and hands off results.
// ----------------------------------------------------------------------------
`include "red_black_laplace_relaxation_assert.svh"

module rbl_ctrl
	import rbl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic [1:0]  op,
	output logic        s_tready,
	input  rbl_status_t status,
	output rbl_cmd_t    cmd
);

	rbl_state_t state_q, state_d;
	logic       accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_WRITE: state_d = S_WRITE;
						OP_RUN:   state_d = status.run_empty ? S_RESP : S_CELL;
						OP_READ:  state_d = S_READ;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_WRITE: state_d = S_IDLE;
			S_READ:  state_d = S_RESP;
			S_CELL: begin
				if (status.cell_odd) begin
					state_d = S_LR;
				end else if (status.scan_end) begin
					state_d = S_RESP;
				end
			end
			S_LR:  state_d = S_SUM;
			S_SUM: state_d = S_WB;
			S_WB:  state_d = status.scan_end ? S_RESP : S_CELL;
			S_RESP: begin
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture  = accept;
				cmd.run_init = accept && (op == OP_RUN);
			end
			S_WRITE: cmd.wr_cell = 1'b1;
			S_READ:  cmd.rd_cell = 1'b1;
			S_CELL: begin
				cmd.rd_ud   = status.cell_odd;
				cmd.advance = !status.cell_odd;
			end
			S_LR: begin
				cmd.rd_lr  = 1'b1;
				cmd.sum_ud = 1'b1;
			end
			S_SUM: cmd.sum_all = 1'b1;
			S_WB: begin
				cmd.wb      = 1'b1;
				cmd.advance = 1'b1;
			end
			S_RESP: cmd.out_load = status.out_free;
			default: cmd = '0;
		endcase
	end

	// assertions
	`RBL_ASSERT_IMP(a_lr_after_odd_cell, state_q == S_LR,
		$past(state_q) == S_CELL && $past(status.cell_odd), "LR step without odd cell")
	`RBL_ASSERT_IMP(a_wb_after_sum, cmd.wb, $past(cmd.sum_all), "write-back without sum")
	`RBL_ASSERT_NXT(a_end_to_resp, cmd.advance && status.scan_end, state_q == S_RESP,
		"run end not reported")

endmodule

FILE: sv/rbl_dp.sv
// ----------------------------------------------------------------------------
// rbl_dp
// Datapath: configuration registers, request capture, run iterators,
// neighbour address generation, quarter-sum adder and output register.
// ----------------------------------------------------------------------------
module rbl_dp
	import rbl_pkg::*;
#(
	parameter int GRID_MAX    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [IN_TDATA_W-1:0]      s_tdata,
	input  logic [IN_TUSER_W-1:0]      s_tuser,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_wdata,
	input  rbl_cmd_t                   cmd,
	output rbl_status_t                status,
	output logic                       ram_we,
	output logic [2*$clog2(GRID_MAX)-1:0] ram_waddr,
	output logic [VALUE_WIDTH-1:0]     ram_wdata,
	output logic                       ram_re,
	output logic [2*$clog2(GRID_MAX)-1:0] ram_raddr_a,
	output logic [2*$clog2(GRID_MAX)-1:0] ram_raddr_b,
	input  logic [VALUE_WIDTH-1:0]     ram_rdata_a,
	input  logic [VALUE_WIDTH-1:0]     ram_rdata_b,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [OUT_TDATA_W-1:0]     m_tdata,
	output logic [0:0]                 m_tuser
);

	localparam int CW = $clog2(GRID_MAX);
	localparam int VW = VALUE_WIDTH;

	logic [GSIZE_W-1:0] grid_size_q;
	logic [SWEEP_W-1:0] sweep_count_q;
	logic [GSIZE_W-1:0] eff;
	logic               inside_in;

	logic [COORD_W-1:0] row_q, col_q;
	logic [VW-1:0]      cell_q;
	logic               inside_q, is_run_q;

	logic [SWEEP_W-1:0] k_q;
	logic [CW-1:0]      srow_q, scol_q;
	logic               last_col, last_row, last_sweep;

	logic [VW:0]        ud_q;
	logic [VW+1:0]      total;
	logic [VW-1:0]      res_q;

	logic               m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic               m_tuser_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q   <= GRID_SIZE_RST;
			sweep_count_q <= SWEEP_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_SIZE:   grid_size_q   <= cfg_wdata[GSIZE_W-1:0];
				CFG_SWEEP_COUNT: sweep_count_q <= cfg_wdata[SWEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// effective grid size and bounds check of the request coordinates
	assign eff = (32'(grid_size_q) > GRID_MAX) ? GSIZE_W'(GRID_MAX) : grid_size_q;
	assign inside_in = ({1'b0, s_tdata[ROW_LSB +: COORD_W]} < eff)
		&& ({1'b0, s_tdata[COL_LSB +: COORD_W]} < eff);

	// request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			is_run_q <= 1'b0;
		end else if (cmd.capture) begin
			inside_q <= inside_in;
			is_run_q <= (s_tuser == OP_RUN);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q  <= s_tdata[ROW_LSB +: COORD_W];
			col_q  <= s_tdata[COL_LSB +: COORD_W];
			cell_q <= VW'($signed(s_tdata[CELL_LSB +: CELL_W]));
		end
	end

	// run iterators: half-sweep, row and column over the interior
	assign last_col   = 32'(scol_q) == 32'(eff) - 32'd2;
	assign last_row   = 32'(srow_q) == 32'(eff) - 32'd2;
	assign last_sweep = k_q == sweep_count_q - SWEEP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			srow_q <= '0;
			scol_q <= '0;
		end else if (cmd.run_init) begin
			k_q    <= '0;
			srow_q <= CW'(1);
			scol_q <= CW'(1);
		end else if (cmd.advance) begin
			if (last_col) begin
				scol_q <= CW'(1);
				if (last_row) begin
					srow_q <= CW'(1);
					k_q    <= k_q + SWEEP_W'(1);
				end else begin
					srow_q <= srow_q + CW'(1);
				end
			end else begin
				scol_q <= scol_q + CW'(1);
			end
		end
	end

	assign status.run_empty = (sweep_count_q == '0) || (eff < GSIZE_W'(3));
	assign status.cell_odd  = srow_q[0] ^ scol_q[0] ^ k_q[0];
	assign status.scan_end  = last_col && last_row && last_sweep;
	assign status.out_free  = !m_tvalid_q || m_tready;

	// memory addressing: cell request, or neighbours of the scan cell
	assign ram_re = cmd.rd_cell || cmd.rd_ud || cmd.rd_lr;

	always_comb begin
		if (cmd.rd_ud) begin
			ram_raddr_a = {srow_q - CW'(1), scol_q};
			ram_raddr_b = {srow_q + CW'(1), scol_q};
		end else if (cmd.rd_lr) begin
			ram_raddr_a = {srow_q, scol_q - CW'(1)};
			ram_raddr_b = {srow_q, scol_q + CW'(1)};
		end else begin
			ram_raddr_a = {CW'(row_q), CW'(col_q)};
			ram_raddr_b = {CW'(row_q), CW'(col_q)};
		end
	end

	assign ram_we = (cmd.wr_cell && inside_q) || cmd.wb;

	always_comb begin
		if (cmd.wb) begin
			ram_waddr = {srow_q, scol_q};
			ram_wdata = res_q;
		end else begin
			ram_waddr = {CW'(row_q), CW'(col_q)};
			ram_wdata = cell_q;
		end
	end

	// quarter sum: up+down first, then add left and right and drop two bits
	assign total = {ud_q[VW], ud_q}
		+ {{2{ram_rdata_a[VW-1]}}, ram_rdata_a}
		+ {{2{ram_rdata_b[VW-1]}}, ram_rdata_b};

	always_ff @(posedge clk) begin
		if (cmd.sum_ud) begin
			ud_q <= {ram_rdata_a[VW-1], ram_rdata_a} + {ram_rdata_b[VW-1], ram_rdata_b};
		end
		if (cmd.sum_all) begin
			res_q <= total[VW+1:2];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tuser_q <= is_run_q;
			if (is_run_q || !inside_q) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= OUT_TDATA_W'(ram_rdata_a);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: sv/red_black_laplace_relaxation.sv
// Write request: stored in the cycle after acceptance, then idle for the next one.
// Read request: RAM read in S_READ, output loaded in S_RESP when free, then back to idle.
// Run request: an updated interior cell goes through S_CELL, S_LR, S_SUM and S_WB (two-port
//   neighbour reads, add, write-back); a skipped cell only advances; S_RESP gives the result.
// Reset (arst_n, asynchronous): controller idle, iterators zero, configuration to defaults.
// Grid memory is not cleared; no clearing pass.
// ----------------------------------------------------------------------------
// red_black_laplace_relaxation
// Red-black Gauss-Seidel relaxation of a square fixed-point grid held in RAM.
// ----------------------------------------------------------------------------
module red_black_laplace_relaxation
	import rbl_pkg::*;
#(
	parameter int GRID_MAX    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // row[5:0], col[11:6], cell_in[43:12], zero pad
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // operation[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // cell_out[31:0]
	output logic [0:0]             m_tuser,   // run_done[0]
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int AW = 2 * $clog2(GRID_MAX);

	rbl_cmd_t         cmd;
	rbl_status_t      status;
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr_a, ram_raddr_b;
	logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

	// controller
	rbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	rbl_dp #(
		.GRID_MAX    (GRID_MAX),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.status      (status),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr_a (ram_raddr_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	// grid memory
	rbl_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (1 << AW)
	) u_grid (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

endmodule

FILE: bench/red_black_laplace_relaxation_tb.sv
// ----------------------------------------------------------------------------
// red_black_laplace_relaxation_tb
// Self-checking bench for the red-black Laplace relaxation block. It loads a
// corner of the grid, then sends directed and random write, read and run
// requests under several register settings. A mirror of the grid predicts
// every response, and each response is checked against it in order.
// ----------------------------------------------------------------------------
module red_black_laplace_relaxation_tb
	import rbl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_MAX       = 64;
	// side of the corner loaded at start; runs that sweep only use grids up to this size
	localparam int LOAD_SIDE      = 16;
	localparam int DRAIN_CYCLES   = 8;
	// longest quiet stretch: a 65535-sweep run on a 3x3 grid, with margin
	localparam int WATCHDOG_LIMIT = 1_500_000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [CELL_W-1:0] cell_out;
		logic              run_done;
	} cell_result_t;

	// grid mirror and in-order store of pending responses
	class relax_scoreboard;
		logic [CELL_W-1:0]  cells [GRID_MAX*GRID_MAX];
		bit                 written [GRID_MAX*GRID_MAX];
		logic [GSIZE_W-1:0] grid_size;
		logic [SWEEP_W-1:0] sweep_count;
		cell_result_t       pending_results [$];
		int unsigned        fail_count;

		function new();
			grid_size   = GRID_SIZE_RST;
			sweep_count = SWEEP_COUNT_RST;
			fail_count  = 0;
			foreach (cells[i]) cells[i] = '0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		// grid side actually in use
		function int side();
			return (grid_size > GRID_MAX) ? GRID_MAX : int'(grid_size);
		endfunction

		function void set_register(logic idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_GRID_SIZE) begin
				grid_size = data[GSIZE_W-1:0];
			end else begin
				sweep_count = data[SWEEP_W-1:0];
			end
		endfunction

		// apply one accepted request to the mirror
		function void note_request(logic [1:0] op, logic [COORD_W-1:0] row,
				logic [COORD_W-1:0] col, logic [CELL_W-1:0] cell_val);
			int n;
			int at;
			bit in_grid;
			longint total;
			n = side();
			in_grid = (row < n) && (col < n);
			case (op)
				OP_WRITE: begin
					if (in_grid) begin
						cells[int'(row)*GRID_MAX + int'(col)]   = cell_val;
						written[int'(row)*GRID_MAX + int'(col)] = 1'b1;
					end
				end
				OP_RUN: begin
					// half-sweep k updates interior cells with row+col+k odd
					if (n >= 3) begin
						for (int k = 0; k < int'(sweep_count); k++) begin
							for (int r = 1; r + 1 < n; r++) begin
								for (int c = 1; c + 1 < n; c++) begin
									if (((r + c + k) & 1) == 1) begin
										at = r*GRID_MAX + c;
										total = longint'($signed(cells[at - GRID_MAX]))
											+ longint'($signed(cells[at + GRID_MAX]))
											+ longint'($signed(cells[at - 1]))
											+ longint'($signed(cells[at + 1]));
										cells[at] = CELL_W'(total >>> 2);
									end
								end
							end
						end
					end
					pending_results.push_back(cell_result_t'{cell_out: '0, run_done: 1'b1});
				end
				OP_READ: begin
					pending_results.push_back(cell_result_t'{
						cell_out: in_grid ? cells[int'(row)*GRID_MAX + int'(col)] : '0,
						run_done: 1'b0});
				end
				default: ;
			endcase
		endfunction

		// compare one accepted response with the oldest prediction
		function void check_response(logic [CELL_W-1:0] cell_out, logic run_done);
			cell_result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected response: cell_out %h run_done %b", cell_out, run_done);
				fail_count++;
				return;
			end
			want = pending_results.pop_front();
			if (cell_out !== want.cell_out) begin
				$error("cell_out: expected %h, actual %h", want.cell_out, cell_out);
				fail_count++;
			end
			if (run_done !== want.run_done) begin
				$error("run_done: expected %b, actual %b", want.run_done, run_done);
				fail_count++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // row[5:0], col[11:6], cell_in[43:12], zero pad
	logic [IN_TUSER_W-1:0]  s_tuser   = '0;  // operation[1:0]
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // cell_out[31:0]
	logic [0:0]             m_tuser;         // run_done[0]
	logic                   cfg_we    = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	relax_scoreboard sb;
	int          src_idle_pct  = 15;
	int          sink_idle_pct = 51;
	int unsigned quiet_cycles  = 0;

	red_black_laplace_relaxation uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_response(m_tdata, m_tuser[0]);
	end

	// watchdog: too long with no request or response moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL red_black_laplace_relaxation");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// mostly random, with extremes and small values near zero
	function automatic logic [CELL_W-1:0] random_cell();
		case ($urandom_range(9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return CELL_W'(int'($urandom_range(64)) - 32);
			default: return $urandom;
		endcase
	endfunction

	// send one request; called and returns at a falling edge
	task automatic send_request(logic [1:0] op, logic [COORD_W-1:0] row,
			logic [COORD_W-1:0] col, logic [CELL_W-1:0] cell_val);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_TDATA_W - CELL_LSB - CELL_W){1'b0}}, cell_val, col, row};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, row, col, cell_val);
		@(negedge clk);
	endtask

	// register write; callers must use it only while the block is idle, the task does not check
	task automatic write_register(logic idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// let every pending response arrive, then let trailing writes settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one random setting followed by a batch of random requests
	task automatic random_block(int unsigned items);
		int unsigned done;
		int n;
		int pick;
		logic [GSIZE_W-1:0] size;
		logic [SWEEP_W-1:0] sweeps;
		logic [1:0] op;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		pick = $urandom_range(9);
		if (pick < 7) begin
			size   = GSIZE_W'($urandom_range(LOAD_SIDE, 3));
			sweeps = SWEEP_W'($urandom_range(6));
		end else if (pick == 7) begin
			size   = GSIZE_W'($urandom_range(2));
			sweeps = SWEEP_W'($urandom_range(20));
		end else if (pick == 8) begin
			// beyond the loaded corner a run does no sweeps
			size   = GSIZE_W'($urandom_range(63, LOAD_SIDE + 1));
			sweeps = '0;
		end else begin
			size   = GSIZE_W'($urandom_range(127, 64));
			sweeps = '0;
		end
		// unused upper bits of the size write carry noise
		write_register(CFG_GRID_SIZE, {9'($urandom), size});
		write_register(CFG_SWEEP_COUNT, sweeps);
		n = sb.side();
		done = 0;
		while (done < items) begin
			pick = $urandom_range(99);
			if (pick < 46)      op = OP_WRITE;
			else if (pick < 88) op = OP_READ;
			else if (pick < 94) op = OP_RUN;
			else                op = OP_UNUSED;
			if (n > 0 && $urandom_range(99) < 85) begin
				row = COORD_W'($urandom_range(n - 1));
				col = COORD_W'($urandom_range(n - 1));
			end else begin
				row = COORD_W'($urandom);
				col = COORD_W'($urandom);
			end
			// a cell never loaded is written before it is read
			if (op == OP_READ && row < n && col < n
					&& !sb.written[int'(row)*GRID_MAX + int'(col)]) begin
				op = OP_WRITE;
			end
			send_request(op, row, col, random_cell());
			// ignored requests do not count
			if (op != OP_UNUSED && !(op == OP_WRITE && !(row < n && col < n))) done++;
		end
		wait_idle();
	endtask

	// stimulus
	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// load the corner used by runs, so no read or run touches an unwritten cell
		for (int r = 0; r < LOAD_SIDE; r++) begin
			for (int c = 0; c < LOAD_SIDE; c++) begin
				send_request(OP_WRITE, COORD_W'(r), COORD_W'(c), random_cell());
			end
		end

		// loaded grid, one half-sweep: most positive neighbours around (1,2)
		write_register(CFG_GRID_SIZE, 16'(LOAD_SIDE));
		write_register(CFG_SWEEP_COUNT, 16'd1);
		send_request(OP_WRITE, 6'd0, 6'd2, 32'h7FFF_FFFF);
		send_request(OP_WRITE, 6'd2, 6'd2, 32'h7FFF_FFFF);
		send_request(OP_WRITE, 6'd1, 6'd1, 32'h7FFF_FFFF);
		send_request(OP_WRITE, 6'd1, 6'd3, 32'h7FFF_FFFF);
		// most negative neighbours around (14,13), touching the last row
		send_request(OP_WRITE, 6'd13, 6'd13, 32'h8000_0000);
		send_request(OP_WRITE, 6'd15, 6'd13, 32'h8000_0000);
		send_request(OP_WRITE, 6'd14, 6'd12, 32'h8000_0000);
		send_request(OP_WRITE, 6'd14, 6'd14, 32'h8000_0000);
		// floor of a small negative sum around (7,8)
		send_request(OP_WRITE, 6'd6, 6'd8, 32'hFFFF_FFFF);
		send_request(OP_WRITE, 6'd8, 6'd8, 32'h0000_0000);
		send_request(OP_WRITE, 6'd7, 6'd7, 32'h0000_0000);
		send_request(OP_WRITE, 6'd7, 6'd9, 32'h0000_0000);
		// border corner stays as written
		send_request(OP_WRITE, 6'd0, 6'd15, 32'h7FFF_FFFF);
		// unused operation gives nothing
		send_request(OP_UNUSED, COORD_W'($urandom), COORD_W'($urandom), $urandom);
		send_request(OP_RUN, 6'd63, 6'd63, 32'hFFFF_FFFF);
		send_request(OP_READ, 6'd1, 6'd2, '0);
		send_request(OP_READ, 6'd14, 6'd13, '0);
		send_request(OP_READ, 6'd7, 6'd8, '0);
		send_request(OP_READ, 6'd0, 6'd15, '0);
		send_request(OP_READ, 6'd2, 6'd2, '0);
		wait_idle();

		// smallest grid with an interior, most sweeps; coordinates beyond it
		write_register(CFG_GRID_SIZE, 16'd3);
		write_register(CFG_SWEEP_COUNT, 16'hFFFF);
		send_request(OP_WRITE, 6'd5, 6'd5, 32'h1234_5678);
		send_request(OP_RUN, '0, '0, '0);
		send_request(OP_READ, 6'd1, 6'd1, '0);
		send_request(OP_READ, 6'd3, 6'd0, '0);
		wait_idle();

		// empty grid, zero sweeps: everything out of range, run still completes
		write_register(CFG_GRID_SIZE, 16'd0);
		write_register(CFG_SWEEP_COUNT, 16'd0);
		send_request(OP_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF);
		send_request(OP_READ, 6'd0, 6'd0, '0);
		send_request(OP_RUN, '0, '0, '0);
		wait_idle();

		// oversized grid acts as the full one: far corner is in range
		write_register(CFG_GRID_SIZE, 16'd127);
		write_register(CFG_SWEEP_COUNT, 16'd0);
		send_request(OP_WRITE, 6'd63, 6'd63, 32'h1234_5678);
		send_request(OP_RUN, '0, '0, '0);
		send_request(OP_READ, 6'd63, 6'd63, '0);
		send_request(OP_READ, 6'd1, 6'd2, '0);
		wait_idle();

		// random part under three idling profiles
		for (int b = 0; b < 6; b++) begin
			if (b == 2) begin
				src_idle_pct  = 51;
				sink_idle_pct = 15;
			end
			if (b == 4) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			random_block(40);
		end

		if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
			$display("PASS red_black_laplace_relaxation");
		end else begin
			$display("FAIL red_black_laplace_relaxation");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/rbl_pkg.sv
sv/rbl_ram.sv
sv/rbl_ctrl.sv
sv/rbl_dp.sv
sv/red_black_laplace_relaxation.sv
bench/red_black_laplace_relaxation_tb.sv
